// ===== hw/rtl/owig_pkg.sv =====
// ----------------------------------------------------------------------------
// owig_pkg
// shared types and constants of the overlap window index gather block
// ----------------------------------------------------------------------------
`default_nettype none

package owig_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned BOX_W      = 48;
  localparam int unsigned OVL_W      = 6;
  localparam int unsigned OWN_FIRST_W = 24;
  localparam int unsigned OWN_END_W  = 25;
  localparam int unsigned BSIZE_W    = 4;
  localparam int unsigned FIRST_W    = 27;
  localparam int unsigned BOUND_W    = 19;
  localparam int unsigned LOC_W      = 49;
  localparam int unsigned PROD_W     = 32;
  localparam int unsigned OWN_CMP_W  = 33;

  localparam logic signed [BOUND_W-1:0] BOUND_ONE = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_GHOST_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GHOST_WIDTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OWNED_FIRST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OWNED_END   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 3'd5;

  localparam logic [BSIZE_W-1:0] BSIZE_MIN = 4'd1;
  localparam logic [BSIZE_W-1:0] BSIZE_MAX = 4'd8;

  typedef struct packed {
    logic [FIRST_W-1:0] first_index;
    logic [BSIZE_W-1:0] run_count;
    logic               empty_res;
    logic               last;
  } owig_res_t;

  typedef struct packed {
    logic idle;
    logic node_vld;
    logic node_hit;
    logic done;
  } owig_walk_t;

endpackage

`default_nettype wire

// ===== hw/rtl/owig_if.sv =====
// ----------------------------------------------------------------------------
// owig_if
// request and result channels of the overlap window index gather block
// ----------------------------------------------------------------------------
`default_nettype none

interface owig_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [11:0] table_addr;
  logic [23:0] table_value;
  logic [15:0] center_x;
  logic [15:0] center_y;
  logic [15:0] center_z;

  modport source (
    output valid, mode, table_addr, table_value, center_x, center_y, center_z,
    input  ready
  );
  modport sink (
    input  valid, mode, table_addr, table_value, center_x, center_y, center_z,
    output ready
  );
endinterface

interface owig_out_if;
  logic        valid;
  logic        ready;
  logic [26:0] first_index;
  logic [3:0]  run_count;
  logic        empty_res;
  logic        last;

  modport source (
    output valid, first_index, run_count, empty_res, last,
    input  ready
  );
  modport sink (
    input  valid, first_index, run_count, empty_res, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/owig_walk.sv =====
// ----------------------------------------------------------------------------
// owig_walk
// clips the window to the ghost box and steps the local slot through it
// ----------------------------------------------------------------------------
`default_nettype none

module owig_walk import owig_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 4096,
  parameter int unsigned MAX_OVERLAP = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [COORD_W-1:0]  center_x_i,
  input  logic [COORD_W-1:0]  center_y_i,
  input  logic [COORD_W-1:0]  center_z_i,
  input  logic [BOX_W-1:0]    box_start_i,
  input  logic [BOX_W-1:0]    box_width_i,
  input  logic [OVL_W-1:0]    overlap_i,
  input  logic                adv_i,
  input  logic                flush_i,
  output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] addr_o,
  output owig_walk_t          stat_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(2 * MAX_OVERLAP + 2);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_BOUND = 3'd1;
  localparam logic [2:0] ST_MUL1  = 3'd2;
  localparam logic [2:0] ST_MUL2  = 3'd3;
  localparam logic [2:0] ST_BASE  = 3'd4;
  localparam logic [2:0] ST_WALK  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]         st_q, st_d;
  logic [COORD_W-1:0] c_q   [3];
  logic [COORD_W-1:0] d_q   [3];
  logic [CW-1:0]      nm1_q [3];
  logic               empty_q;
  logic [PROD_W-1:0]  p_q, m1_q;
  logic [BOX_W-1:0]   m2_q;
  logic [LOC_W-1:0]   loc_q, lj_q, li_q;
  logic [CW-1:0]      ck_q, cj_q, ci_q;

  logic [1:0]                ovf   [3];
  logic signed [BOUND_W-1:0] cs    [3];
  logic signed [BOUND_W-1:0] ovs   [3];
  logic signed [BOUND_W-1:0] gss   [3];
  logic signed [BOUND_W-1:0] gend  [3];
  logic signed [BOUND_W-1:0] lo_s  [3];
  logic signed [BOUND_W-1:0] hi_s  [3];
  logic [2:0]                empty_ax;
  logic [COORD_W-1:0]        gw0, gw1;
  logic                      k_end, j_end, i_end;

  assign gw0 = box_width_i[COORD_W-1:0];
  assign gw1 = box_width_i[2*COORD_W-1:COORD_W];

  // window bounds per axis
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ovf[a] = (overlap_i[2*a +: 2] > 2'(MAX_OVERLAP)) ? 2'(MAX_OVERLAP)
                                                        : overlap_i[2*a +: 2];
      cs[a]   = signed'(BOUND_W'(c_q[a]));
      ovs[a]  = signed'(BOUND_W'(ovf[a]));
      gss[a]  = signed'(BOUND_W'(box_start_i[COORD_W*a +: COORD_W]));
      gend[a] = gss[a] + signed'(BOUND_W'(box_width_i[COORD_W*a +: COORD_W]))
                - BOUND_ONE;
      lo_s[a] = ((cs[a] - ovs[a]) > gss[a]) ? (cs[a] - ovs[a]) : gss[a];
      hi_s[a] = ((cs[a] + ovs[a]) < gend[a]) ? (cs[a] + ovs[a]) : gend[a];
      empty_ax[a] = hi_s[a] < lo_s[a];
    end
  end

  assign k_end = ck_q == nm1_q[2];
  assign j_end = cj_q == nm1_q[1];
  assign i_end = ci_q == nm1_q[0];

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:  if (start_i) st_d = ST_BOUND;
      ST_BOUND: st_d = ST_MUL1;
      ST_MUL1:  st_d = ST_MUL2;
      ST_MUL2:  st_d = ST_BASE;
      ST_BASE:  st_d = empty_q ? ST_DONE : ST_WALK;
      ST_WALK:  if (adv_i && k_end && j_end && i_end) st_d = ST_DONE;
      ST_DONE:  if (flush_i) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      ck_q <= '0;
      cj_q <= '0;
      ci_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_BASE) begin
        ck_q <= '0;
        cj_q <= '0;
        ci_q <= '0;
      end else if (st_q == ST_WALK && adv_i) begin
        priority if (!k_end) begin
          ck_q <= ck_q + CW'(1);
        end else if (!j_end) begin
          ck_q <= '0;
          cj_q <= cj_q + CW'(1);
        end else if (!i_end) begin
          ck_q <= '0;
          cj_q <= '0;
          ci_q <= ci_q + CW'(1);
        end else begin
          ck_q <= ck_q;
        end
      end
    end
  end

  // slot arithmetic: k step adds wx*wy, j step adds wx, i step adds one
  always_ff @(posedge clk_i) begin
    if (start_i && st_q == ST_IDLE) begin
      c_q[0] <= center_x_i;
      c_q[1] <= center_y_i;
      c_q[2] <= center_z_i;
    end
    if (st_q == ST_BOUND) begin
      for (int a = 0; a < 3; a++) begin
        d_q[a]   <= COORD_W'(lo_s[a] - gss[a]);
        nm1_q[a] <= CW'(hi_s[a] - lo_s[a]);
      end
      empty_q <= |empty_ax;
    end
    if (st_q == ST_MUL1) begin
      p_q  <= PROD_W'(gw0) * PROD_W'(gw1);
      m1_q <= PROD_W'(d_q[1]) * PROD_W'(gw0);
    end
    if (st_q == ST_MUL2) begin
      m2_q <= BOX_W'(d_q[2]) * BOX_W'(p_q);
    end
    if (st_q == ST_BASE) begin
      loc_q <= LOC_W'(d_q[0]) + LOC_W'(m1_q) + LOC_W'(m2_q);
      lj_q  <= LOC_W'(d_q[0]) + LOC_W'(m1_q) + LOC_W'(m2_q);
      li_q  <= LOC_W'(d_q[0]) + LOC_W'(m1_q) + LOC_W'(m2_q);
    end else if (st_q == ST_WALK && adv_i) begin
      priority if (!k_end) begin
        loc_q <= loc_q + LOC_W'(p_q);
      end else if (!j_end) begin
        lj_q  <= lj_q + LOC_W'(gw0);
        loc_q <= lj_q + LOC_W'(gw0);
      end else begin
        li_q  <= li_q + LOC_W'(1);
        lj_q  <= li_q + LOC_W'(1);
        loc_q <= li_q + LOC_W'(1);
      end
    end
  end

  assign addr_o          = loc_q[AW-1:0];
  assign stat_o.idle     = st_q == ST_IDLE;
  assign stat_o.node_vld = st_q == ST_WALK;
  assign stat_o.node_hit = loc_q < LOC_W'(TABLE_DEPTH);
  assign stat_o.done     = st_q == ST_DONE;

endmodule

`default_nettype wire

// ===== hw/rtl/overlap_window_index_gather.sv =====
// ----------------------------------------------------------------------------
// overlap_window_index_gather
// Node table and window walk that lists owned index runs around a node.
//
// The request channel carries a table load (mode 0) or a window query
// (mode 1); the result channel carries one index run per owned node of the
// window, in x, y, z order with z innermost, the final one marked last. A
// query whose window holds no owned node gives one result marked empty.
// Configuration is written through cfg_we_i/cfg_addr_i/cfg_data_i; the user
// must write it only while the block is idle, which the block does not enforce.
// A load gives no result. A query passes the setup states BOUND, MUL1,
// MUL2 and BASE for the box clipping and the slot multiplies, then walks
// one window node per cycle while the output does not stall, at most
// (2*MAX_OVERLAP+1)^3 nodes and 27 at an overlap of one, set by the single
// read port of the node table, then drains the read stage and closes.
// A query is taken only when the previous one is closed; a load then too.
// The latest kept run is held back one step so that last can be marked.
// When the receiver stalls, the output register and that held run fill and
// the walk pauses; nothing is dropped.
// Reset clears control and configuration (block_size to one); the node
// table contents are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module overlap_window_index_gather import owig_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 4096,
  parameter int unsigned MAX_OVERLAP = 1,
  parameter int unsigned GLOBAL_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  owig_in_if.sink               req_i,
  owig_out_if.source            res_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned PW = GLOBAL_BITS + BSIZE_W;

  logic [BOX_W-1:0]       gs_q, gw_q;
  logic [OVL_W-1:0]       ovl_q;
  logic [OWN_FIRST_W-1:0] own_first_q;
  logic [OWN_END_W-1:0]   own_end_q;
  logic [BSIZE_W-1:0]     bsize_q;

  logic [GLOBAL_BITS-1:0] mem_q [TABLE_DEPTH];
  logic [GLOBAL_BITS-1:0] rd_q;
  logic                   s1_vld_q, s1_hit_q;
  logic                   pend_vld_q;
  logic [FIRST_W-1:0]     pend_first_q;
  logic                   out_vld_q;
  owig_res_t              out_q;

  owig_walk_t             walk;
  logic [AW-1:0]          raddr;
  logic                   req_fire, start, mem_we, adv;
  logic                   owned, keep, s1_go, out_free, flush;
  logic [BSIZE_W-1:0]     bs;
  logic [FIRST_W-1:0]     new_first;

  assign req_i.ready = walk.idle;
  assign req_fire    = req_i.valid && walk.idle;
  assign start       = req_fire && req_i.mode;
  assign mem_we      = req_fire && !req_i.mode &&
                       (32'(req_i.table_addr) < 32'(TABLE_DEPTH));

  owig_walk #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_OVERLAP (MAX_OVERLAP)
  ) u_walk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .center_x_i    (req_i.center_x),
    .center_y_i    (req_i.center_y),
    .center_z_i    (req_i.center_z),
    .box_start_i   (gs_q),
    .box_width_i   (gw_q),
    .overlap_i     (ovl_q),
    .adv_i         (adv),
    .flush_i       (flush),
    .addr_o        (raddr),
    .stat_o        (walk)
  );

  // node table
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[AW'(req_i.table_addr)] <= GLOBAL_BITS'(req_i.table_value);
    end
    if (adv && walk.node_vld && walk.node_hit) begin
      rd_q <= mem_q[raddr];
    end
  end

  assign bs = (bsize_q == '0) ? BSIZE_MIN :
              (bsize_q > BSIZE_MAX) ? BSIZE_MAX : bsize_q;

  assign owned     = (OWN_CMP_W'(rd_q) >= OWN_CMP_W'(own_first_q)) &&
                     (OWN_CMP_W'(rd_q) <  OWN_CMP_W'(own_end_q));
  assign keep      = s1_vld_q && s1_hit_q && owned;
  assign new_first = FIRST_W'(PW'(bs) * PW'(rd_q));
  assign out_free  = !out_vld_q || res_o.ready;
  assign s1_go     = !keep || !pend_vld_q || out_free;
  assign adv       = !s1_vld_q || s1_go;
  assign flush     = walk.done && !s1_vld_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gs_q        <= '0;
      gw_q        <= '0;
      ovl_q       <= '0;
      own_first_q <= '0;
      own_end_q   <= '0;
      bsize_q     <= BSIZE_MIN;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_GHOST_START: gs_q        <= cfg_data_i[BOX_W-1:0];
        CFG_GHOST_WIDTH: gw_q        <= cfg_data_i[BOX_W-1:0];
        CFG_OVERLAP:     ovl_q       <= cfg_data_i[OVL_W-1:0];
        CFG_OWNED_FIRST: own_first_q <= cfg_data_i[OWN_FIRST_W-1:0];
        CFG_OWNED_END:   own_end_q   <= cfg_data_i[OWN_END_W-1:0];
        CFG_BLOCK_SIZE:  bsize_q     <= cfg_data_i[BSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      s1_hit_q   <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (adv) begin
        s1_vld_q <= walk.node_vld;
        s1_hit_q <= walk.node_hit;
      end
      if (keep && s1_go) begin
        pend_vld_q <= 1'b1;
      end else if (flush) begin
        pend_vld_q <= 1'b0;
      end
      if ((keep && pend_vld_q && out_free) || flush) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // held run goes out when a newer one arrives or the walk closes
  always_ff @(posedge clk_i) begin
    if (keep && s1_go) begin
      pend_first_q <= new_first;
    end
    if (keep && pend_vld_q && out_free) begin
      out_q.first_index <= pend_first_q;
      out_q.run_count   <= bs;
      out_q.empty_res   <= 1'b0;
      out_q.last        <= 1'b0;
    end else if (flush) begin
      out_q.first_index <= pend_vld_q ? pend_first_q : '0;
      out_q.run_count   <= pend_vld_q ? bs : '0;
      out_q.empty_res   <= !pend_vld_q;
      out_q.last        <= 1'b1;
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.first_index = out_q.first_index;
  assign res_o.run_count   = out_q.run_count;
  assign res_o.empty_res   = out_q.empty_res;
  assign res_o.last        = out_q.last;

endmodule

`default_nettype wire
